// ===== design/ddp_pixel_packet_receiver_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pixel packet receiver
// Shared property shapes, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DDP_PIXEL_PACKET_RECEIVER_CORE_DEFINES_SVH
`define DDP_PIXEL_PACKET_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication
`define DDPRX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DDPRX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ddprx_pkg.sv =====
// ----------------------------------------------------------------------------
// ddprx_pkg
// Types, codes and helpers shared by the pixel packet receiver modules.
// ----------------------------------------------------------------------------
package ddprx_pkg;

  // default limits
  localparam int MAX_FRAME_PIXELS_DEF = 131072;
  localparam int MAX_DATAGRAM_DEF     = 2048;

  // header layout
  localparam int HDR_BYTES     = 10;
  localparam int IDX_FLAGS     = 0;
  localparam int IDX_FORMAT    = 2;
  localparam int IDX_ID        = 3;
  localparam int IDX_OFF_FIRST = 4;
  localparam int IDX_OFF_LAST  = 7;
  localparam int IDX_LEN_FIRST = 8;
  localparam int IDX_LEN_LAST  = HDR_BYTES - 1;

  // flag bits
  localparam int FLAG_VERSION = 6;  // 0x40
  localparam int FLAG_PUSH    = 0;  // 0x01

  // result kinds
  localparam logic [1:0] KIND_PIXEL   = 2'd0;
  localparam logic [1:0] KIND_PRESENT = 2'd1;
  localparam logic [1:0] KIND_TAKE    = 2'd2;

  // buffer targets
  localparam logic [1:0] TGT_FRONT  = 2'd0;
  localparam logic [1:0] TGT_BACK_A = 2'd1;
  localparam logic [1:0] TGT_BACK_B = 2'd2;

  // buffer modes
  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  // packet actions
  localparam logic [1:0] ACT_DROP      = 2'd0;
  localparam logic [1:0] ACT_NO_PIXELS = 2'd1;
  localparam logic [1:0] ACT_RGB888    = 2'd2;
  localparam logic [1:0] ACT_RGB565    = 2'd3;

  // register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_ID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BYTES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_RGB888  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_565_LE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_565_BE  = 3'd6;

  // register reset values
  localparam logic [7:0]  RST_STREAM_ID    = 8'd1;
  localparam logic [17:0] RST_FRAME_PIXELS = 18'd0;
  localparam logic [1:0]  RST_BUFFER_MODE  = MODE_DIRECT;
  localparam logic        RST_SWAP_BYTES   = 1'b0;
  localparam logic [7:0]  RST_CODE_RGB888  = 8'd11;
  localparam logic [7:0]  RST_CODE_565_LE  = 8'd97;
  localparam logic [7:0]  RST_CODE_565_BE  = 8'd98;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        cmd;
    logic [7:0]  byte_value;
    logic [11:0] packet_length;
    logic        last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  target_buffer;
    logic [16:0] pixel_index;
    logic [15:0] pixel_data;
    logic        flag;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  stream_id;
    logic [17:0] frame_pixels;
    logic [1:0]  buffer_mode;
    logic        swap_bytes;
    logic [7:0]  code_rgb888;
    logic [7:0]  code_rgb565_le;
    logic [7:0]  code_rgb565_be;
  } cfg_t;

  // up to two results per word, w0 first
  typedef struct packed {
    logic [1:0] n;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

  typedef struct packed {
    logic              space2;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic [7:0] q;
    logic [1:0] r;
  } div3_t;

  // one digit of a running divide by three: t = rem * 256 + byte, t < 768
  function automatic div3_t div3_step(input logic [9:0] t);
    logic [20:0] p;
    logic [9:0]  q3;
    div3_t       res;
    p     = 21'(t) * 21'd683;
    res.q = p[18:11];
    q3    = 10'({res.q, 1'b0}) + 10'(res.q);
    res.r = 2'(t - q3);
    return res;
  endfunction

endpackage

// ===== design/ddprx_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ddprx_cfg_regs
// Configuration register file; flags a frame size or mode change.
// ----------------------------------------------------------------------------
module ddprx_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ddprx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ddprx_pkg::CFG_DATA_W-1:0] cfg_data,
  output ddprx_pkg::cfg_t                 cfg,
  output logic                            clr_pending
);
  import ddprx_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt     = cfg_r;
    clr_pending = 1'b0;
    if (wr) begin
      unique case (cfg_index)
        CFG_STREAM_ID:    cfg_nxt.stream_id = cfg_data[7:0];
        CFG_FRAME_PIXELS: begin
          cfg_nxt.frame_pixels = cfg_data;
          clr_pending          = (cfg_data != cfg_r.frame_pixels);
        end
        CFG_BUFFER_MODE:  begin
          cfg_nxt.buffer_mode = cfg_data[1:0];
          clr_pending         = (cfg_data[1:0] != cfg_r.buffer_mode);
        end
        CFG_SWAP_BYTES:   cfg_nxt.swap_bytes     = cfg_data[0];
        CFG_CODE_RGB888:  cfg_nxt.code_rgb888    = cfg_data[7:0];
        CFG_CODE_565_LE:  cfg_nxt.code_rgb565_le = cfg_data[7:0];
        CFG_CODE_565_BE:  cfg_nxt.code_rgb565_be = cfg_data[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stream_id      <= RST_STREAM_ID;
      cfg_r.frame_pixels   <= RST_FRAME_PIXELS;
      cfg_r.buffer_mode    <= RST_BUFFER_MODE;
      cfg_r.swap_bytes     <= RST_SWAP_BYTES;
      cfg_r.code_rgb888    <= RST_CODE_RGB888;
      cfg_r.code_rgb565_le <= RST_CODE_565_LE;
      cfg_r.code_rgb565_be <= RST_CODE_565_BE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/ddprx_parser.sv =====
// ----------------------------------------------------------------------------
// ddprx_parser
// Header capture, accept decision, pixel assembly and buffer handling.
// ----------------------------------------------------------------------------
module ddprx_parser #(
  parameter int MAX_FRAME_PIXELS = ddprx_pkg::MAX_FRAME_PIXELS_DEF,
  parameter int MAX_DATAGRAM     = ddprx_pkg::MAX_DATAGRAM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  ddprx_pkg::in_word_t item,
  input  ddprx_pkg::cfg_t     cfg,
  input  logic                clr_pending,
  output ddprx_pkg::push_t    push
);
  import ddprx_pkg::*;

  localparam int PIX_W = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int BC_W  = $clog2(MAX_DATAGRAM + 1);

  // state
  logic [BC_W-1:0]  byte_count_r, byte_count_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [7:0]       format_r, format_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [31:0]      offset_r, offset_nxt;
  logic [15:0]      length_r, length_nxt;
  logic [31:0]      off_q_r, off_q_nxt;
  logic [1:0]       off_rem_r, off_rem_nxt;
  logic [15:0]      len_q_r, len_q_nxt;
  logic [1:0]       len_rem_r, len_rem_nxt;
  logic [1:0]       action_r, action_nxt;
  logic [PIX_W-1:0] next_pixel_r, next_pixel_nxt;
  logic [PIX_W-1:0] pixels_left_r, pixels_left_nxt;
  logic [15:0]      partial_r, partial_nxt;
  logic [1:0]       partial_cnt_r, partial_cnt_nxt;
  logic             back_sel_r, back_sel_nxt;
  logic             pending_r, pending_nxt;

  logic [BC_W-1:0]  idx;
  logic [7:0]       b;
  logic [16:0]      n_eff;
  logic [PIX_W-1:0] fp;
  logic [1:0]       mode_eff;
  logic [1:0]       wr_tgt;

  // running divide by three of offset and length
  div3_t            off_div, len_div;
  logic [15:0]      len_shift;
  logic [15:0]      len_q_new;

  // accept decision
  logic             unit3, unit2, aligned, base_ok, too_long, po_in;
  logic [31:0]      po;
  logic [15:0]      px;
  logic [32:0]      span;
  logic [1:0]       dec_action;
  logic             dec_pix;
  logic [PIX_W-1:0] dec_left;

  // pixel data
  logic [15:0]      c888, d888, d565;
  logic             src_be;

  out_word_t        pix_w, pres_w, take_w;
  logic             pix_v, pres_v;

  assign idx = byte_count_r;
  assign b   = item.byte_value;

  assign n_eff = (17'(item.packet_length) < 17'(MAX_DATAGRAM)) ?
                 17'(item.packet_length) : 17'(MAX_DATAGRAM);
  assign fp    = (32'(cfg.frame_pixels) > 32'(MAX_FRAME_PIXELS)) ?
                 PIX_W'(MAX_FRAME_PIXELS) : PIX_W'(cfg.frame_pixels);
  assign mode_eff = cfg.buffer_mode[1] ? MODE_DOUBLE : cfg.buffer_mode;

  always_comb begin
    unique case (mode_eff)
      MODE_DIRECT: wr_tgt = TGT_FRONT;
      MODE_SINGLE: wr_tgt = TGT_BACK_A;
      default:     wr_tgt = back_sel_r ? TGT_BACK_B : TGT_BACK_A;
    endcase
  end

  assign off_div = div3_step((idx == BC_W'(IDX_OFF_FIRST)) ? {2'b00, b} : {off_rem_r, b});
  assign len_div = div3_step((idx == BC_W'(IDX_LEN_FIRST)) ? {2'b00, b} : {len_rem_r, b});
  assign len_shift = {length_r[7:0], b};
  assign len_q_new = (idx == BC_W'(IDX_LEN_FIRST)) ? 16'(len_div.q) : {len_q_r[7:0], len_div.q};

  // decision on the last header byte
  always_comb begin
    unit3    = (format_r == cfg.code_rgb888);
    unit2    = !unit3 && (format_r == cfg.code_rgb565_le || format_r == cfg.code_rgb565_be);
    aligned  = unit3 ? (off_rem_r == 2'd0 && len_div.r == 2'd0)
                     : (!offset_r[0] && !len_shift[0]);
    po       = unit3 ? off_q_r : {1'b0, offset_r[31:1]};
    px       = unit3 ? len_q_new : {1'b0, len_shift[15:1]};
    span     = 33'(fp) - 33'(po);
    po_in    = !span[32] && (span != 33'd0);
    base_ok  = (n_eff >= 17'(HDR_BYTES)) && flags_r[FLAG_VERSION] &&
               (id_r == cfg.stream_id) && (fp != '0);
    too_long = (17'(HDR_BYTES) + 17'(len_shift)) > n_eff;
    dec_action = ACT_DROP;
    dec_pix    = 1'b0;
    dec_left   = '0;
    if (base_ok) begin
      if (len_shift == 16'd0) begin
        dec_action = flags_r[FLAG_PUSH] ? ACT_NO_PIXELS : ACT_DROP;
      end else if (!too_long && (unit3 || unit2)) begin
        dec_action = ACT_NO_PIXELS;
        if (aligned && po_in) begin
          dec_action = unit3 ? ACT_RGB888 : ACT_RGB565;
          dec_pix    = 1'b1;
          dec_left   = (33'(px) < span) ? PIX_W'(px) : PIX_W'(span);
        end
      end
    end
  end

  // RGB888 -> RGB565, and RGB565 byte order
  assign c888   = {partial_r[15:11], partial_r[7:2], b[7:3]};
  assign d888   = cfg.swap_bytes ? {c888[7:0], c888[15:8]} : c888;
  assign src_be = (format_r == cfg.code_rgb565_be);
  assign d565   = (src_be == cfg.swap_bytes) ? {b, partial_r[7:0]} : {partial_r[7:0], b};

  always_comb begin
    byte_count_nxt  = byte_count_r;
    flags_nxt       = flags_r;
    format_nxt      = format_r;
    id_nxt          = id_r;
    offset_nxt      = offset_r;
    length_nxt      = length_r;
    off_q_nxt       = off_q_r;
    off_rem_nxt     = off_rem_r;
    len_q_nxt       = len_q_r;
    len_rem_nxt     = len_rem_r;
    action_nxt      = action_r;
    next_pixel_nxt  = next_pixel_r;
    pixels_left_nxt = pixels_left_r;
    partial_nxt     = partial_r;
    partial_cnt_nxt = partial_cnt_r;
    back_sel_nxt    = back_sel_r;
    pending_nxt     = pending_r;
    pix_v           = 1'b0;
    pres_v          = 1'b0;
    pix_w           = '0;
    pres_w          = '0;
    take_w          = '0;
    push            = '0;

    pix_w.kind          = KIND_PIXEL;
    pix_w.target_buffer = wr_tgt;
    pix_w.pixel_index   = 17'(next_pixel_r);
    pix_w.pixel_data    = (action_r == ACT_RGB888) ? d888 : d565;

    pres_w.kind          = KIND_PRESENT;
    pres_w.target_buffer = wr_tgt;
    pres_w.flag          = (mode_eff == MODE_DOUBLE) ? pending_r : 1'b0;

    take_w.kind          = KIND_TAKE;
    take_w.target_buffer = (pending_r && mode_eff == MODE_DOUBLE) ?
                           (back_sel_r ? TGT_BACK_A : TGT_BACK_B) : TGT_FRONT;
    take_w.flag          = pending_r;
    take_w.last          = 1'b1;

    if (go) begin
      if (item.cmd) begin
        pending_nxt = 1'b0;
        push.n      = 2'd1;
        push.w0     = take_w;
      end else begin
        if (idx < BC_W'(MAX_DATAGRAM)) byte_count_nxt = byte_count_r + 1'b1;

        if (idx < BC_W'(HDR_BYTES)) begin
          if (idx == BC_W'(IDX_FLAGS)) begin
            flags_nxt = b;
          end else if (idx == BC_W'(IDX_FORMAT)) begin
            format_nxt = b;
          end else if (idx == BC_W'(IDX_ID)) begin
            id_nxt = b;
          end else if (idx >= BC_W'(IDX_OFF_FIRST) && idx <= BC_W'(IDX_OFF_LAST)) begin
            offset_nxt  = {offset_r[23:0], b};
            off_q_nxt   = (idx == BC_W'(IDX_OFF_FIRST)) ? 32'(off_div.q)
                                                        : {off_q_r[23:0], off_div.q};
            off_rem_nxt = off_div.r;
          end else if (idx >= BC_W'(IDX_LEN_FIRST)) begin
            length_nxt  = len_shift;
            len_q_nxt   = len_q_new;
            len_rem_nxt = len_div.r;
          end
          if (idx == BC_W'(IDX_LEN_LAST)) begin
            action_nxt      = dec_action;
            pixels_left_nxt = dec_left;
            partial_nxt     = '0;
            partial_cnt_nxt = '0;
            if (dec_pix) next_pixel_nxt = PIX_W'(po);
          end
        end else if (idx < BC_W'(MAX_DATAGRAM) &&
                     (action_r == ACT_RGB888 || action_r == ACT_RGB565) &&
                     pixels_left_r != '0) begin
          if (partial_cnt_r < ((action_r == ACT_RGB888) ? 2'd2 : 2'd1)) begin
            partial_nxt     = {partial_r[7:0], b};
            partial_cnt_nxt = partial_cnt_r + 2'd1;
          end else begin
            pix_v           = 1'b1;
            next_pixel_nxt  = next_pixel_r + 1'b1;
            pixels_left_nxt = pixels_left_r - 1'b1;
            partial_nxt     = '0;
            partial_cnt_nxt = '0;
          end
        end

        if (item.last_byte) begin
          if (idx >= BC_W'(IDX_LEN_LAST) && action_nxt != ACT_DROP && flags_r[FLAG_PUSH]) begin
            pres_v = 1'b1;
            if (mode_eff == MODE_DOUBLE) begin
              back_sel_nxt = !back_sel_r;
              pending_nxt  = 1'b1;
            end
          end
          byte_count_nxt  = '0;
          action_nxt      = ACT_DROP;
          pixels_left_nxt = '0;
          partial_nxt     = '0;
          partial_cnt_nxt = '0;
        end

        if (pix_v && pres_v) begin
          push.n       = 2'd2;
          push.w0      = pix_w;
          push.w1      = pres_w;
          push.w1.last = 1'b1;
        end else if (pix_v) begin
          push.n       = 2'd1;
          push.w0      = pix_w;
          push.w0.last = 1'b1;
        end else if (pres_v) begin
          push.n       = 2'd1;
          push.w0      = pres_w;
          push.w0.last = 1'b1;
        end
      end
    end

    if (clr_pending) pending_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      flags_r       <= '0;
      format_r      <= '0;
      id_r          <= '0;
      offset_r      <= '0;
      length_r      <= '0;
      off_q_r       <= '0;
      off_rem_r     <= '0;
      len_q_r       <= '0;
      len_rem_r     <= '0;
      action_r      <= ACT_DROP;
      next_pixel_r  <= '0;
      pixels_left_r <= '0;
      partial_r     <= '0;
      partial_cnt_r <= '0;
      back_sel_r    <= 1'b0;
      pending_r     <= 1'b0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      flags_r       <= flags_nxt;
      format_r      <= format_nxt;
      id_r          <= id_nxt;
      offset_r      <= offset_nxt;
      length_r      <= length_nxt;
      off_q_r       <= off_q_nxt;
      off_rem_r     <= off_rem_nxt;
      len_q_r       <= len_q_nxt;
      len_rem_r     <= len_rem_nxt;
      action_r      <= action_nxt;
      next_pixel_r  <= next_pixel_nxt;
      pixels_left_r <= pixels_left_nxt;
      partial_r     <= partial_nxt;
      partial_cnt_r <= partial_cnt_nxt;
      back_sel_r    <= back_sel_nxt;
      pending_r     <= pending_nxt;
    end
  end

endmodule

// ===== design/ddprx_result_queue.sv =====
// ----------------------------------------------------------------------------
// ddprx_result_queue
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module ddprx_result_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ddprx_pkg::push_t     push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ddprx_pkg::out_word_t out_data,
  output ddprx_pkg::q_stat_t   stat
);
  import ddprx_pkg::*;

  out_word_t         q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QPTR_W-1:0] wr_ptr_1;
  logic [QCNT_W-1:0] cnt_after_pop;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  assign cnt_after_pop = cnt_r - QCNT_W'(pop);
  assign stat.space2   = (cnt_after_pop <= QCNT_W'(QDEPTH - 2));
  assign stat.count    = cnt_r;

  assign wr_ptr_1   = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.n);
  assign rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
  assign cnt_nxt    = cnt_after_pop + QCNT_W'(push.n);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) q_r[wr_ptr_r] <= push.w0;
    if (push.n == 2'd2) q_r[wr_ptr_1] <= push.w1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== design/ddp_pixel_packet_receiver_core.sv =====
// ----------------------------------------------------------------------------
// ddp_pixel_packet_receiver_core
// Display datagram receiver: parses the header byte by byte and turns the
// payload into RGB565 pixel writes, present events and take replies.
// ----------------------------------------------------------------------------
//
//   port group  dir  handshake            word
//   ----------  ---  -------------------  -------------------------------
//   in_*        in   in_valid/in_ready    one datagram byte or take cmd
//   out_*       out  out_valid/out_ready  pixel write / present / reply
//   cfg_*       in   cfg_valid/cfg_ready  register index + write data
//
// One word is taken per clock. It is worked on straight out of the input
// register, in the cycle after it is taken unless the queue is short of room,
// and its results (none, one or two) land in a four-deep result queue at the
// edge that ends that cycle. Input stalls only when the queue could not take
// two more results, so a stalled output still lets one word in. Reset is
// synchronous, active low, and needs no clearing pass; cfg_ready is always high.
//
`include "ddp_pixel_packet_receiver_core_defines.svh"

module ddp_pixel_packet_receiver_core #(
  parameter int MAX_FRAME_PIXELS = ddprx_pkg::MAX_FRAME_PIXELS_DEF,
  parameter int MAX_DATAGRAM     = ddprx_pkg::MAX_DATAGRAM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // byte input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ddprx_pkg::in_word_t              in_data,
  // results
  output logic                             out_valid,
  input  logic                             out_ready,
  output ddprx_pkg::out_word_t             out_data,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ddprx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddprx_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ddprx_pkg::*;

  // input register
  logic     s1_valid_r, s1_valid_nxt;
  in_word_t s1_r;
  logic     in_take;
  logic     go;           // word in s1 is processed this cycle

  cfg_t     cfg;
  logic     clr_pending;
  push_t    push;
  q_stat_t  qstat;

  // a word is worked on only when the queue has room for two results
  assign go       = s1_valid_r && qstat.space2;
  assign in_ready = !s1_valid_r || go;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (in_take) s1_r <= in_data;
  end

  ddprx_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cfg         (cfg),
    .clr_pending (clr_pending)
  );

  ddprx_parser #(
    .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
    .MAX_DATAGRAM     (MAX_DATAGRAM)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .item        (s1_r),
    .cfg         (cfg),
    .clr_pending (clr_pending),
    .push        (push)
  );

  ddprx_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (qstat)
  );

  // checks
  `DDPRX_ASSERT_IMP(a_no_push_idle, !go, push.n == 2'd0, "results pushed with no word in work")
  `DDPRX_ASSERT_IMP(a_take_single, go && s1_r.cmd, push.n == 2'd1 && push.w0.kind == KIND_TAKE && push.w0.last, "take must give one reply")
  `DDPRX_ASSERT_IMP(a_pair_order, push.n == 2'd2, push.w0.kind == KIND_PIXEL && push.w1.kind == KIND_PRESENT && !push.w0.last && push.w1.last, "bad result pair")
  `DDPRX_ASSERT_IMP(a_queue_bound, qstat.count != '0 || !out_valid, qstat.count <= QCNT_W'(QDEPTH), "result queue overflow")

endmodule

// ===== tb/ddp_pixel_packet_receiver_core_tb.sv =====
// ----------------------------------------------------------------------------
// ddp_pixel_packet_receiver_core_tb
// Self-checking bench for the display datagram receiver. Byte and take words
// go in over valid/ready; every accepted word is run through a predictor of
// the header parser, pixel converter and buffer swap logic, and each result
// word is compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddp_pixel_packet_receiver_core_tb;
  import ddprx_pkg::*;

  localparam int         PHASE_WORDS    = 190;        // random words per setting
  localparam int         NUM_PHASES     = 8;
  localparam int         PHASE_DIRECTED = 8;
  localparam int         PHASE_DEFAULTS = 10;
  localparam int         DRAIN_CYCLES   = 6;          // input register and result queue, plus margin
  localparam int         MAX_REPORTS    = 40;
  localparam longint     TIMEOUT_NS     = 10_000_000; // time limit for the whole run
  localparam logic [1:0] MODE_ALIAS     = 2'd3;       // behaves as two buffers
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  localparam logic [7:0] HDR_VERSION_PUSH = (8'd1 << FLAG_VERSION) | (8'd1 << FLAG_PUSH);

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the result words of each accepted word and checks
  // the block's output against them in order.
  // --------------------------------------------------------------------------
  class rx_scoreboard;
    // register copy
    logic [7:0]  stream_id;
    logic [17:0] frame_pixels;
    logic [1:0]  buffer_mode;
    logic        swap_bytes;
    logic [7:0]  code_888, code_le, code_be;
    // parser state
    int unsigned byte_count;
    logic [7:0]  hdr_flags, hdr_format, hdr_id;
    logic [31:0] hdr_offset;
    logic [15:0] hdr_length;
    logic [1:0]  action;
    int unsigned next_pixel, pixels_left, partial_count;
    logic [15:0] partial_bytes;
    logic        back_select, ready_pending;

    out_word_t   pending_results[$];
    int unsigned fail_count, results_checked, pixels_seen, presents_seen, takes_seen;

    function new();
      stream_id    = RST_STREAM_ID;
      frame_pixels = RST_FRAME_PIXELS;
      buffer_mode  = RST_BUFFER_MODE;
      swap_bytes   = RST_SWAP_BYTES;
      code_888     = RST_CODE_RGB888;
      code_le      = RST_CODE_565_LE;
      code_be      = RST_CODE_565_BE;
      byte_count   = 0;
      hdr_flags    = '0;
      hdr_format   = '0;
      hdr_id       = '0;
      hdr_offset   = '0;
      hdr_length   = '0;
      action       = ACT_DROP;
      next_pixel   = 0;
      pixels_left  = 0;
      partial_count = 0;
      partial_bytes = '0;
      back_select  = 1'b0;
      ready_pending = 1'b0;
      fail_count   = 0;
      results_checked = 0;
      pixels_seen  = 0;
      presents_seen = 0;
      takes_seen   = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    task report(string msg);
      if (fail_count < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
      fail_count++;
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_STREAM_ID:    stream_id = val[7:0];
        CFG_FRAME_PIXELS: begin
          if (val != frame_pixels) ready_pending = 1'b0;
          frame_pixels = val;
        end
        CFG_BUFFER_MODE:  begin
          if (val[1:0] != buffer_mode) ready_pending = 1'b0;
          buffer_mode = val[1:0];
        end
        CFG_SWAP_BYTES:   swap_bytes = val[0];
        CFG_CODE_RGB888:  code_888 = val[7:0];
        CFG_CODE_565_LE:  code_le = val[7:0];
        CFG_CODE_565_BE:  code_be = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [1:0] eff_mode();
      return (buffer_mode > MODE_DOUBLE) ? MODE_DOUBLE : buffer_mode;
    endfunction

    // buffer currently being filled
    function logic [1:0] fill_target();
      case (eff_mode())
        MODE_DIRECT: return TGT_FRONT;
        MODE_SINGLE: return TGT_BACK_A;
        default:     return back_select ? TGT_BACK_B : TGT_BACK_A;
      endcase
    endfunction

    function out_word_t make_result(logic [1:0] kind, logic [1:0] tgt, logic [16:0] idx,
                                    logic [15:0] data, logic flag);
      out_word_t r;
      r.kind          = kind;
      r.target_buffer = tgt;
      r.pixel_index   = idx;
      r.pixel_data    = data;
      r.flag          = flag;
      r.last          = 1'b0;
      return r;
    endfunction

    // accept/drop decision once the tenth header byte is in
    function void decide_packet(int unsigned n);
      int unsigned fp, unit, px;
      logic [31:0] po;
      fp = (frame_pixels > MAX_FRAME_PIXELS_DEF) ? MAX_FRAME_PIXELS_DEF : frame_pixels;
      unit = 0;
      action = ACT_DROP;
      pixels_left = 0;
      partial_count = 0;
      partial_bytes = '0;
      if (n < HDR_BYTES || !hdr_flags[FLAG_VERSION] || hdr_id != stream_id || fp == 0)
        return;
      if (hdr_length == 0) begin
        action = hdr_flags[FLAG_PUSH] ? ACT_NO_PIXELS : ACT_DROP;
        return;
      end
      if (HDR_BYTES + int'(hdr_length) > int'(n)) return;
      if (hdr_format == code_888) unit = 3;
      else if (hdr_format == code_le || hdr_format == code_be) unit = 2;
      if (unit == 0) return;
      action = ACT_NO_PIXELS;
      if (hdr_offset % unit == 0 && hdr_length % unit == 0) begin
        po = hdr_offset / unit;
        px = hdr_length / unit;
        if (po < fp) begin
          action      = (unit == 3) ? ACT_RGB888 : ACT_RGB565;
          next_pixel  = po;
          pixels_left = (px < fp - po) ? px : fp - po;
        end
      end
    endfunction

    function void note_word(in_word_t w);
      out_word_t   res[$];
      int unsigned n, pos, need;
      logic [1:0]  tgt;
      logic [15:0] px;
      logic [7:0]  b;
      b = w.byte_value;
      n = (w.packet_length < MAX_DATAGRAM_DEF) ? w.packet_length : MAX_DATAGRAM_DEF;
      if (w.cmd) begin
        tgt = (ready_pending && eff_mode() == MODE_DOUBLE) ?
              (back_select ? TGT_BACK_A : TGT_BACK_B) : TGT_FRONT;
        res.push_back(make_result(KIND_TAKE, tgt, '0, '0, ready_pending));
        ready_pending = 1'b0;
      end else begin
        pos = byte_count;
        if (pos < MAX_DATAGRAM_DEF) byte_count = pos + 1;
        if (pos < HDR_BYTES) begin
          if (pos == IDX_FLAGS) hdr_flags = b;
          else if (pos == IDX_FORMAT) hdr_format = b;
          else if (pos == IDX_ID) hdr_id = b;
          else if (pos >= IDX_OFF_FIRST && pos <= IDX_OFF_LAST)
            hdr_offset = {hdr_offset[23:0], b};
          else if (pos >= IDX_LEN_FIRST) hdr_length = {hdr_length[7:0], b};
          if (pos == IDX_LEN_LAST) decide_packet(n);
        end else if (pos < MAX_DATAGRAM_DEF && action >= ACT_RGB888 && pixels_left > 0) begin
          need = (action == ACT_RGB888) ? 2 : 1;
          if (partial_count < need) begin
            partial_bytes = {partial_bytes[7:0], b};
            partial_count++;
          end else begin
            if (action == ACT_RGB888) begin
              px = {partial_bytes[15:11], partial_bytes[7:2], b[7:3]};
              if (swap_bytes) px = {px[7:0], px[15:8]};
            end else begin
              // byte order in memory follows swap_bytes; source order follows format
              px = ((hdr_format == code_be) == swap_bytes) ?
                   {b, partial_bytes[7:0]} : {partial_bytes[7:0], b};
            end
            res.push_back(make_result(KIND_PIXEL, fill_target(), next_pixel[16:0], px, 1'b0));
            next_pixel++;
            pixels_left--;
            partial_count = 0;
            partial_bytes = '0;
          end
        end
        if (w.last_byte) begin
          if (pos >= IDX_LEN_LAST && action != ACT_DROP && hdr_flags[FLAG_PUSH]) begin
            res.push_back(make_result(KIND_PRESENT, fill_target(), '0, '0,
                                      (eff_mode() == MODE_DOUBLE) ? ready_pending : 1'b0));
            if (eff_mode() == MODE_DOUBLE) begin
              back_select   = ~back_select;
              ready_pending = 1'b1;
            end
          end
          byte_count    = 0;
          action        = ACT_DROP;
          pixels_left   = 0;
          partial_count = 0;
          partial_bytes = '0;
        end
      end
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
      foreach (res[i]) pending_results.push_back(res[i]);
    endfunction

    task check_result(out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing expected: kind %0d tgt %0d idx %0d data %h",
                         got.kind, got.target_buffer, got.pixel_index, got.pixel_data));
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      case (want.kind)
        KIND_PIXEL:   pixels_seen++;
        KIND_PRESENT: presents_seen++;
        default:      takes_seen++;
      endcase
      if (got.kind !== want.kind || got.target_buffer !== want.target_buffer ||
          got.pixel_index !== want.pixel_index || got.pixel_data !== want.pixel_data ||
          got.flag !== want.flag || got.last !== want.last)
        report($sformatf({"result %0d got/exp: kind %0d/%0d tgt %0d/%0d idx %0d/%0d ",
                          "data %h/%h flag %0d/%0d last %0d/%0d"}, results_checked,
                         got.kind, want.kind, got.target_buffer, want.target_buffer,
                         got.pixel_index, want.pixel_index, got.pixel_data, want.pixel_data,
                         got.flag, want.flag, got.last, want.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and its ports. All inputs start at known values.
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  always #5 clk = ~clk;

  ddp_pixel_packet_receiver_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rx_scoreboard sb;
  cfg_t         cur_cfg;          // settings the stimulus aims at
  int unsigned  idle_pct  = 0;    // sender gap chance per cycle, percent
  int unsigned  stall_pct = 0;    // receiver stall chance per cycle, percent
  bit           mid_takes = 1'b0; // sprinkle take words inside datagrams
  int unsigned  words_sent = 0;
  int unsigned  settings_used = 0;
  logic [7:0]   dgram[$];         // datagram under construction

  // Receiver side: ready toggles at random per the current stall rate.
  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Monitor: samples handshakes at the edge, before anything is re-driven.
  // Results are checked before the same edge's input is noted; a word's
  // results never appear at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_word(in_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One word on the input channel; random gaps come before valid rises, so
  // valid never drops while a word is on offer.
  task automatic send_word(in_word_t w);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Take command; the unused fields carry noise.
  task automatic send_take();
    in_word_t w;
    w.cmd           = 1'b1;
    w.byte_value    = 8'($urandom);
    w.packet_length = 12'($urandom);
    w.last_byte     = 1'($urandom);
    send_word(w);
  endtask

  task automatic send_dgram(int unsigned plen, bit end_flag);
    in_word_t w;
    foreach (dgram[i]) begin
      if (mid_takes && $urandom_range(39) == 0) send_take();
      w.cmd           = 1'b0;
      w.byte_value    = dgram[i];
      w.packet_length = plen[11:0];
      w.last_byte     = end_flag && (i == dgram.size() - 1);
      send_word(w);
    end
  endtask

  task automatic build_header(logic [7:0] flags, logic [7:0] fmt, logic [7:0] id,
                              logic [31:0] off, logic [15:0] hlen);
    dgram.delete();
    dgram.push_back(flags);
    dgram.push_back(8'($urandom)); // sequence, unused
    dgram.push_back(fmt);
    dgram.push_back(id);
    dgram.push_back(off[31:24]);
    dgram.push_back(off[23:16]);
    dgram.push_back(off[15:8]);
    dgram.push_back(off[7:0]);
    dgram.push_back(hlen[15:8]);
    dgram.push_back(hlen[7:0]);
  endtask

  task automatic add_random_bytes(int unsigned count);
    repeat (count) dgram.push_back(8'($urandom));
  endtask

  // One register write; bits above the register's width carry noise.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value,
                           int unsigned width);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    for (int b = 0; b < width; b++) data[b] = value[b];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_config(cfg_t c, bit with_unmapped);
    cfg_write(CFG_STREAM_ID, CFG_DATA_W'(c.stream_id), 8);
    cfg_write(CFG_FRAME_PIXELS, c.frame_pixels, CFG_DATA_W);
    cfg_write(CFG_BUFFER_MODE, CFG_DATA_W'(c.buffer_mode), 2);
    cfg_write(CFG_SWAP_BYTES, CFG_DATA_W'(c.swap_bytes), 1);
    cfg_write(CFG_CODE_RGB888, CFG_DATA_W'(c.code_rgb888), 8);
    cfg_write(CFG_CODE_565_LE, CFG_DATA_W'(c.code_rgb565_le), 8);
    cfg_write(CFG_CODE_565_BE, CFG_DATA_W'(c.code_rgb565_be), 8);
    if (with_unmapped) cfg_write(CFG_UNMAPPED, CFG_DATA_W'($urandom), 0);
    cfg_valid <= 1'b0;
    cur_cfg = c;
    settings_used++;
  endtask

  // Let everything in flight come out; words with no result may still be in
  // the pipe when the queue empties, hence the extra cycles.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic cfg_t phase_cfg(int p);
    cfg_t c;
    c.stream_id      = RST_STREAM_ID;
    c.frame_pixels   = RST_FRAME_PIXELS;
    c.buffer_mode    = RST_BUFFER_MODE;
    c.swap_bytes     = RST_SWAP_BYTES;
    c.code_rgb888    = RST_CODE_RGB888;
    c.code_rgb565_le = RST_CODE_565_LE;
    c.code_rgb565_be = RST_CODE_565_BE;
    case (p)
      0: c.frame_pixels = 18'd64;
      1: begin
        c.stream_id = 8'hFF; c.frame_pixels = 18'd131072;
        c.buffer_mode = MODE_DOUBLE; c.swap_bytes = 1'b1;
      end
      2: begin
        // oversize frame saturates; extreme format codes
        c.stream_id = 8'h00; c.frame_pixels = 18'h3FFFF; c.buffer_mode = MODE_SINGLE;
        c.code_rgb888 = 8'h00; c.code_rgb565_le = 8'hFF; c.code_rgb565_be = 8'h80;
      end
      3: begin
        // one-pixel frame, mode alias, LE and BE sharing a code
        c.stream_id = 8'd42; c.frame_pixels = 18'd1; c.buffer_mode = MODE_ALIAS;
        c.swap_bytes = 1'b1;
        c.code_rgb888 = 8'hFF; c.code_rgb565_le = 8'h00; c.code_rgb565_be = 8'h00;
      end
      4: begin
        // RGB888 and LE sharing a code
        c.stream_id = 8'd7; c.frame_pixels = 18'd300; c.buffer_mode = MODE_DOUBLE;
        c.code_rgb888 = 8'd5; c.code_rgb565_le = 8'd5; c.code_rgb565_be = 8'd9;
      end
      5: begin
        c.frame_pixels = 18'd96; c.buffer_mode = MODE_DOUBLE; c.swap_bytes = 1'b1;
      end
      6: begin
        c.stream_id = 8'd200; c.frame_pixels = 18'd131071; c.swap_bytes = 1'b1;
      end
      7: begin
        c.frame_pixels = 18'd50; c.buffer_mode = MODE_DOUBLE;
      end
      PHASE_DIRECTED: begin
        c.frame_pixels = 18'd64; c.buffer_mode = MODE_DOUBLE;
      end
      default: ;
    endcase
    return c;
  endfunction

  // One random datagram, mostly well formed, with header faults, short and
  // noisy datagrams and the odd missing end marker mixed in.
  task automatic rand_dgram();
    int unsigned fp, unit, po, npx, len, hlen, plen, r, s;
    logic [7:0]  flags, fmt, id;
    logic [31:0] off;
    bit          end_flag;
    r = $urandom_range(99);
    if (r >= 90 && r < 97) begin
      dgram.delete();
      if (r < 94) begin
        // ends inside the header
        dgram.push_back(HDR_VERSION_PUSH);
        add_random_bytes($urandom_range(0, 8));
      end else begin
        add_random_bytes($urandom_range(10, 40));
      end
      send_dgram($urandom_range(0, 4095), 1'b1);
      return;
    end
    fp = (cur_cfg.frame_pixels > MAX_FRAME_PIXELS_DEF) ?
         MAX_FRAME_PIXELS_DEF : cur_cfg.frame_pixels;
    case ($urandom_range(2))
      0:       fmt = cur_cfg.code_rgb888;
      1:       fmt = cur_cfg.code_rgb565_le;
      default: fmt = cur_cfg.code_rgb565_be;
    endcase
    unit = (fmt == cur_cfg.code_rgb888) ? 3 : 2;
    s = $urandom_range(9);
    if (fp == 0) po = $urandom_range(3);
    else if (s < 4) po = $urandom_range(fp - 1);
    else if (s < 8) po = $urandom_range((fp < 16) ? fp - 1 : 15);
    else po = ((fp > 4) ? fp - 4 : 0) + $urandom_range(6);   // around the frame end
    npx  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
    len  = npx * unit;
    hlen = len;
    off  = po * unit;
    flags = 8'($urandom);
    flags[FLAG_VERSION] = 1'b1;
    flags[FLAG_PUSH]    = ($urandom_range(3) != 0);
    id = cur_cfg.stream_id;
    end_flag = 1'b1;
    if (r < 62) begin
    end else if (r < 70) begin
      if ($urandom_range(1)) off = off + 1;
      else begin
        len  = len + 1;
        hlen = len;
      end
    end else if (r < 74) off = $urandom;
    else if (r < 78) flags[FLAG_VERSION] = 1'b0;
    else if (r < 82) id = id ^ 8'(1 << $urandom_range(7));
    else if (r < 86) begin
      do fmt = 8'($urandom);
      while (fmt == cur_cfg.code_rgb888 || fmt == cur_cfg.code_rgb565_le ||
             fmt == cur_cfg.code_rgb565_be);
    end else if (r < 90) hlen = len + $urandom_range(1, 6);  // payload overruns datagram
    else end_flag = 1'b0;                                    // end marker missing
    build_header(flags, fmt, id, off, 16'(hlen));
    add_random_bytes(len);
    if ($urandom_range(9) == 0) add_random_bytes($urandom_range(1, 4));
    plen = dgram.size();
    if ($urandom_range(19) == 0) plen = $urandom_range(plen, 4095);
    send_dgram(plen, end_flag);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results still expected", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned start;
    sb = new();
    cur_cfg = phase_cfg(PHASE_DEFAULTS);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings first (zero frame drops everything), written
    // back explicitly so same-value writes are seen too.
    write_config(phase_cfg(PHASE_DEFAULTS), 1'b0);
    send_take();                                    // nothing ready yet
    dgram.delete();
    dgram.push_back(HDR_VERSION_PUSH);
    dgram.push_back(8'h00);
    dgram.push_back(RST_CODE_RGB888);
    send_dgram(3, 1'b1);                            // ends inside the header
    wait_idle();

    // Two-buffer mode, 64-pixel frame: RGB888 starting on the last pixel,
    // so the second pixel is clipped; then PUSH and a take of that frame.
    write_config(phase_cfg(PHASE_DIRECTED), 1'b0);
    build_header(HDR_VERSION_PUSH, RST_CODE_RGB888, RST_STREAM_ID, 32'd189, 16'd6);
    dgram.push_back(8'hFF); dgram.push_back(8'hFF); dgram.push_back(8'hFF);
    dgram.push_back(8'h00); dgram.push_back(8'h00); dgram.push_back(8'h00);
    send_dgram(16, 1'b1);
    send_take();

    // Random phases, cycling the idle/stall patterns over the settings.
    mid_takes = 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_config(phase_cfg(p), p == 0);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) begin
        if ($urandom_range(99) < 8) send_take();
        else rand_dgram();
      end
    end

    wait_idle();
    $display("Run covered %0d words over %0d register settings: %0d pixel writes,",
             words_sent, settings_used, sb.pixels_seen);
    $display("  %0d present events and %0d take replies checked, %0d mismatches",
             sb.presents_seen, sb.takes_seen, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== ddp_pixel_packet_receiver_core.f =====
+incdir+design
design/ddprx_pkg.sv
design/ddprx_cfg_regs.sv
design/ddprx_parser.sv
design/ddprx_result_queue.sv
design/ddp_pixel_packet_receiver_core.sv
tb/ddp_pixel_packet_receiver_core_tb.sv
